// ===== rtl/ismt_pkg.sv =====
`default_nettype none
package ismt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  localparam logic [FUNC_W-1:0] FN_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CONTAINS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // lookup word walking down the row of cells
  typedef struct packed {
    logic               vld;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic               found;
    logic               free_seen;
  } tok_t;

  // end-of-row decision broadcast back to every cell
  typedef struct packed {
    logic en;
    logic insert;
  } commit_t;

endpackage
`default_nettype wire

// ===== rtl/ismt_cell.sv =====
`default_nettype none
module ismt_cell
  import ismt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire tok_t    tok_in,
  input  wire commit_t commit,
  output tok_t         tok_out,
  output logic         cand
);

  logic [VALUE_W-1:0] entry;
  logic               valid;
  logic               match;
  logic               take_free;
  tok_t               tok_next;

  assign match     = tok_in.vld && valid && (entry == tok_in.value);
  // first empty cell seen by an add claims the slot until the commit
  assign take_free = tok_in.vld && (tok_in.func == FN_ADD) && !valid && !tok_in.free_seen;

  always_comb begin
    tok_next           = tok_in;
    tok_next.found     = tok_in.found | match;
    tok_next.free_seen = tok_in.free_seen | !valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      cand        <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (commit.en) begin
        cand <= 1'b0;
        if (commit.insert && cand) begin
          valid <= 1'b1;
        end
      end else if (take_free) begin
        cand <= 1'b1;
      end
      if (match && (tok_in.func == FN_REMOVE)) begin
        valid <= 1'b0;
      end
    end
  end

  // entry is empty here, so parking the value early is harmless
  always_ff @(posedge clk) begin
    if (take_free) begin
      entry <= tok_in.value;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/integer_set_membership_table_unit.sv =====
`default_nettype none
// Set of up to CAPACITY distinct 32-bit integers held in a row of cells. A command
// (func, value) is taken when start is high and busy is low; the lookup word then
// walks down the row one cell per cycle, and at the edge after it leaves the last
// cell the add is committed and done pulses for one cycle with status and count. Busy
// stays high until then, so the next start is taken at the edge that ends the done
// cycle; a new command is taken only once the last one is through. The receiver cannot
// stall: status and count are valid only while done is high.
module integer_set_membership_table_unit
  import ismt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [COUNT_W-1:0]       count
);

  localparam int CW = $clog2(CAPACITY + 1);

  tok_t              tok [CAPACITY+1];
  logic [CAPACITY-1:0] cand_vec;
  logic [CAPACITY:0]   tok_vld_vec;
  commit_t           commit;
  tok_t              last;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [STATUS_W-1:0] status_next;

  // vld, func, value, found, free_seen
  assign tok[0] = {start && !busy, func, value, 1'b0, 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ismt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .commit  (commit),
      .tok_out (tok[i+1]),
      .cand    (cand_vec[i])
    );
  end

  for (genvar i = 0; i <= CAPACITY; i++) begin : g_vld
    assign tok_vld_vec[i] = tok[i].vld;
  end

  assign last = tok[CAPACITY];

  always_comb begin
    commit.en     = last.vld;
    commit.insert = 1'b0;
    cnt_next      = cnt;
    status_next   = last.found ? ST_OK : ST_MISS;
    case (last.func)
      FN_ADD: begin
        if (last.found) begin
          status_next = ST_MISS;
        end else if (last.free_seen) begin
          status_next   = ST_OK;
          commit.insert = last.vld;
          cnt_next      = cnt + 1'b1;
        end else begin
          status_next = ST_FULL;
        end
      end
      FN_REMOVE: begin
        if (last.found) begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= last.vld;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (last.vld) begin
        busy <= 1'b0;
      end
      if (last.vld) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.vld) begin
      status <= status_next;
    end
  end

  assign count = COUNT_W'(cnt);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_one_cand: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cand_vec))
    else $error("more than one cell claimed a free slot");

  a_one_tok: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld_vec[CAPACITY:1]))
    else $error("two lookup words in the cell row");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $countones(tok_vld_vec[CAPACITY:1]) == 0))
    else $error("done while a lookup is still in flight");

endmodule
`default_nettype wire

// ===== dv/integer_set_membership_table_unit_test.sv =====
`timescale 1ns / 100ps

module integer_set_membership_table_unit_test;
  import ismt_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int LATENCY = CAPACITY + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;  // unused code, behaves as contains
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } set_reply_t;

  // Tracks table contents and holds the replies still owed by the block.
  class membership_scoreboard;
    logic [VALUE_W-1:0] slot_value[CAPACITY];
    bit slot_live[CAPACITY];
    int unsigned held;
    set_reply_t replies_due[$];
    int errors;

    function void note_command(logic [FUNC_W-1:0] op, logic [VALUE_W-1:0] v);
      int hit;
      int slot;
      set_reply_t r;
      hit = -1;
      slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit < 0 && slot_live[i] && slot_value[i] == v) hit = i;
        if (slot < 0 && !slot_live[i]) slot = i;
      end
      case (op)
        FN_ADD: begin
          if (hit >= 0) begin
            r.status = ST_MISS;
          end else if (slot < 0 || held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slot_value[slot] = v;
            slot_live[slot] = 1'b1;
            held++;
            r.status = ST_OK;
          end
        end
        FN_REMOVE: begin
          if (hit >= 0) begin
            slot_live[hit] = 1'b0;
            if (held > 0) held--;
            r.status = ST_OK;
          end else begin
            r.status = ST_MISS;
          end
        end
        default: r.status = (hit >= 0) ? ST_OK : ST_MISS;
      endcase
      r.count = COUNT_W'(held);
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
      set_reply_t r;
      if (replies_due.size() == 0) begin
        $error("done with no word outstanding: status %0d count %0d", st, cnt);
        errors++;
      end else begin
        r = replies_due.pop_front();
        if (st !== r.status) begin
          $error("status mismatch: expected %0d actual %0d", r.status, st);
          errors++;
        end
        if (cnt !== r.count) begin
          $error("count mismatch: expected %0d actual %0d", r.count, cnt);
          errors++;
        end
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] func;
  logic signed [VALUE_W-1:0] value;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] count;

  membership_scoreboard sb;
  int idle_pct;
  int add_pct;
  int cycle_count;
  logic [VALUE_W-1:0] value_pool[POOL_SIZE];

  integer_set_membership_table_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .done(done),
    .status(status),
    .count(count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, count);
      if (start && !busy) sb.note_command(func, value);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_set_membership_table_unit verification failed");
      $finish;
    end
  end

  // Present one word and hold it until taken, then maybe leave a gap.
  task automatic issue_command(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 24);
      @(negedge clk);
      start <= 1'b0;
      func <= FUNC_W'($urandom);
      value <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_command();
    int r;
    logic [FUNC_W-1:0] f;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 5) f = FN_SPARE;
    else if (r < add_pct) f = FN_ADD;
    else if (r < add_pct + (100 - add_pct) * 2 / 3) f = FN_REMOVE;
    else f = FN_CONTAINS;
    // mostly a small pool so hits, duplicates and a full table are common
    if ($urandom_range(9) == 0) v = $urandom;
    else v = value_pool[$urandom_range(POOL_SIZE - 1)];
    issue_command(f, v);
  endtask

  initial begin
    int pcts[3];
    sb = new;
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    func = '0;
    value = '0;
    idle_pct = 37;
    add_pct = 50;
    pcts[0] = 37;
    pcts[1] = 69;
    pcts[2] = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, spare code, fill, full, free and refill
    issue_command(FN_CONTAINS, 32'h0000_0000);
    issue_command(FN_REMOVE, 32'h0000_0000);
    issue_command(FN_ADD, 32'h8000_0000);
    issue_command(FN_ADD, 32'h7fff_ffff);
    issue_command(FN_ADD, 32'h0000_0000);
    issue_command(FN_ADD, 32'hffff_ffff);
    issue_command(FN_ADD, 32'hffff_ffff);
    issue_command(FN_SPARE, 32'h7fff_ffff);
    issue_command(FN_SPARE, 32'h1234_5678);
    for (int i = 0; i < CAPACITY - 4; i++) issue_command(FN_ADD, 32'h0000_1000 + i);
    drain_replies();
    issue_command(FN_ADD, 32'h5555_aaaa);
    issue_command(FN_ADD, 32'h8000_0000);
    issue_command(FN_REMOVE, 32'h0000_0000);
    issue_command(FN_REMOVE, 32'h0000_0000);
    issue_command(FN_ADD, 32'h5555_aaaa);

    for (int p = 0; p < 3; p++) begin
      idle_pct = pcts[p];
      for (int n = 0; n < 234; n++) begin
        // swing between filling and emptying phases
        add_pct = ((n / 40) % 2 == 0) ? 70 : 25;
        random_command();
        if (n == 117) drain_replies();
      end
    end

    drain_replies();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("integer_set_membership_table_unit verification clean");
    end else begin
      $display("integer_set_membership_table_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ismt_pkg.sv
rtl/ismt_cell.sv
rtl/integer_set_membership_table_unit.sv
dv/integer_set_membership_table_unit_test.sv
